// File: rtl/core/sbfi_pkg.sv
// Package for the segment / box face intersect unit.
// Holds the shared types, face tables and pipeline depth constants.
// No dependencies.
package sbfi_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic [30:0] HALF_RESET = 31'(32'd1 << FRAC_BITS);

    localparam int NFACE  = 6;
    localparam int NLANE  = 12;

    // quotient bits per divider stage, root bits per sqrt stage
    localparam int DIV_BITS = 32;
    localparam int DIV_PER  = 2;
    localparam int DIV_STG  = DIV_BITS / DIV_PER;
    localparam int SQ_BITS  = 34;
    localparam int SQ_PER   = 2;
    localparam int SQ_STG   = SQ_BITS / SQ_PER;

    typedef logic [1:0] t_axis;

    localparam t_axis FACE_AXIS [NFACE] = '{2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2};
    localparam logic  FACE_POS  [NFACE] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    typedef enum logic [2:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_HALF_X   = 3'd3,
        CFG_HALF_Y   = 3'd4,
        CFG_HALF_Z   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0][31:0] center;
        logic [2:0][30:0] half;
    } t_box;

    typedef struct packed {
        logic             hit;
        logic [2:0]       face;
        logic [2:0][31:0] point;
        logic [32:0]      dlen;
    } t_res;

    typedef struct packed {
        logic valid;
        logic two;
        t_res r0;
        t_res r1;
    } t_core_out;

    // the two axes other than a, in increasing order
    function automatic t_axis other_axis(input t_axis a, input logic k);
        t_axis o;
        case (a)
            2'd0:    o = k ? 2'd2 : 2'd1;
            2'd1:    o = k ? 2'd2 : 2'd0;
            default: o = k ? 2'd1 : 2'd0;
        endcase
        return o;
    endfunction

endpackage

// File: rtl/core/sbfi_core.sv
// Intersection datapath: face setup, 12 pipelined dividers, inside test,
// hit selection, squares and a pipelined square root. Uses sbfi_pkg.
// Advances as a whole on i_adv.
module sbfi_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_in_valid,
    input  logic [2:0][31:0]     i_s,
    input  logic [2:0][31:0]     i_e,
    input  sbfi_pkg::t_box       i_box,
    output sbfi_pkg::t_core_out  o_out
);
    import sbfi_pkg::*;

    function automatic logic [63:0] div_steps(input logic [31:0] rem_i,
                                              input logic [31:0] lo_i,
                                              input logic [31:0] d);
        logic [32:0] sh;
        logic [31:0] rem;
        logic [31:0] lo;
        rem = rem_i;
        lo  = lo_i;
        for (int i = 0; i < DIV_PER; i++) begin
            sh = {rem, lo[31]};
            lo = {lo[30:0], 1'b0};
            if (sh >= {1'b0, d}) begin
                sh    = sh - {1'b0, d};
                lo[0] = 1'b1;
            end
            rem = sh[31:0];
        end
        return {rem, lo};
    endfunction

    function automatic logic [137:0] sq_steps(input logic [35:0] rem_i,
                                              input logic [33:0] root_i,
                                              input logic [67:0] rad_i);
        logic [37:0] acc;
        logic [37:0] trial;
        logic [35:0] rem;
        logic [33:0] root;
        logic [67:0] rad;
        rem  = rem_i;
        root = root_i;
        rad  = rad_i;
        for (int i = 0; i < SQ_PER; i++) begin
            acc   = {rem, rad[67:66]};
            rad   = {rad[65:0], 2'b00};
            trial = {2'b00, root, 2'b01};
            if (acc >= trial) begin
                acc  = acc - trial;
                root = {root[32:0], 1'b1};
            end else begin
                root = {root[32:0], 1'b0};
            end
            rem = acc[35:0];
        end
        return {rem, root, rad};
    endfunction

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -35'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // box bounds per axis and face planes
    logic signed [33:0] w_lo_b [3];
    logic signed [33:0] w_hi_b [3];
    logic signed [33:0] w_plane [NFACE];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_lo_b[i] = 34'($signed(i_box.center[i])) - $signed({3'b000, i_box.half[i]});
            w_hi_b[i] = 34'($signed(i_box.center[i])) + $signed({3'b000, i_box.half[i]});
        end
        for (int f = 0; f < NFACE; f++)
            w_plane[f] = FACE_POS[f] ? w_hi_b[FACE_AXIS[f]] : w_lo_b[FACE_AXIS[f]];
    end

    // stage 1: input
    logic               r1_v;
    logic signed [31:0] r1_s [3];
    logic signed [31:0] r1_e [3];

    // stage 2: setup
    logic signed [32:0] w_d   [3];
    logic signed [32:0] w_dn  [3];
    logic signed [34:0] w_num [NFACE];
    logic signed [34:0] w_nn  [NFACE];
    logic signed [34:0] w_den [NFACE];
    logic [NFACE-1:0]   w_ok;

    logic               r2_v;
    logic signed [31:0] r2_s [3];
    logic [2:0]         r2_dneg;
    logic [NFACE-1:0]   r2_ok;
    logic [31:0]        r2_uden [NFACE];
    logic [31:0]        r2_unum [NFACE];
    logic [31:0]        r2_ud [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i]  = 33'(r1_e[i]) - 33'(r1_s[i]);
            w_dn[i] = -w_d[i];
        end
        for (int f = 0; f < NFACE; f++) begin
            w_num[f] = 35'(w_plane[f]) - 35'(r1_s[FACE_AXIS[f]]);
            w_nn[f]  = -w_num[f];
            w_den[f] = 35'(w_d[FACE_AXIS[f]]);
            if (w_den[f] == 35'sd0)
                w_ok[f] = 1'b0;
            else if (!w_den[f][34])
                w_ok[f] = !w_num[f][34] && (w_num[f] <= w_den[f]);
            else
                w_ok[f] = (w_num[f] <= 35'sd0) && (w_num[f] >= w_den[f]);
        end
    end

    // stage 3: products
    logic               r3_v;
    logic signed [31:0] r3_s [3];
    logic [2:0]         r3_dneg;
    logic [NFACE-1:0]   r3_ok;
    logic [31:0]        r3_uden [NFACE];
    logic [63:0]        r3_prod [NLANE];

    // divider stages
    logic               rd_v    [DIV_STG];
    logic signed [31:0] rd_s    [DIV_STG][3];
    logic [2:0]         rd_dneg [DIV_STG];
    logic [NFACE-1:0]   rd_ok   [DIV_STG];
    logic [31:0]        rd_uden [DIV_STG][NFACE];
    logic [31:0]        rd_rem  [DIV_STG][NLANE];
    logic [31:0]        rd_lo   [DIV_STG][NLANE];

    // R1: rounding, signs, plane and numerator
    logic [32:0]        w_q   [NLANE];
    logic               w_neg [NLANE];
    logic signed [34:0] w_num4 [NFACE];

    logic               r4_v;
    logic signed [31:0] r4_s [3];
    logic [NFACE-1:0]   r4_ok;
    logic [32:0]        r4_q [NLANE];
    logic               r4_neg [NLANE];
    logic signed [33:0] r4_plane [NFACE];
    logic signed [34:0] r4_num [NFACE];

    always_comb begin
        for (int f = 0; f < NFACE; f++) begin
            w_num4[f] = 35'(w_plane[f]) - 35'(rd_s[DIV_STG-1][FACE_AXIS[f]]);
            for (int k = 0; k < 2; k++) begin
                w_q[2*f+k] = {1'b0, rd_lo[DIV_STG-1][2*f+k]}
                           + 33'({rd_rem[DIV_STG-1][2*f+k], 1'b0}
                                 >= {1'b0, rd_uden[DIV_STG-1][f]});
                w_neg[2*f+k] = w_num4[f][34]
                             ^ rd_dneg[DIV_STG-1][other_axis(FACE_AXIS[f], k[0])]
                             ^ rd_dneg[DIV_STG-1][FACE_AXIS[f]];
            end
        end
    end

    // R2: point coordinates
    logic               r5_v;
    logic [NFACE-1:0]   r5_ok;
    logic [32:0]        r5_q [NLANE];
    logic signed [34:0] r5_p [NLANE];
    logic signed [33:0] r5_plane [NFACE];
    logic signed [34:0] r5_num [NFACE];
    logic signed [34:0] w_p [NLANE];

    always_comb begin
        for (int f = 0; f < NFACE; f++)
            for (int k = 0; k < 2; k++)
                w_p[2*f+k] = r4_neg[2*f+k]
                    ? 35'(r4_s[other_axis(FACE_AXIS[f], k[0])]) - $signed(35'(r4_q[2*f+k]))
                    : 35'(r4_s[other_axis(FACE_AXIS[f], k[0])]) + $signed(35'(r4_q[2*f+k]));
    end

    // R3: inside test
    logic               r6_v;
    logic [NFACE-1:0]   r6_hit;
    logic [32:0]        r6_q [NLANE];
    logic signed [34:0] r6_p [NLANE];
    logic signed [33:0] r6_plane [NFACE];
    logic signed [34:0] r6_num [NFACE];
    logic [NFACE-1:0]   w_hit;
    logic [NLANE-1:0]   w_in;

    always_comb begin
        for (int f = 0; f < NFACE; f++) begin
            for (int k = 0; k < 2; k++)
                w_in[2*f+k] =
                    (r5_p[2*f+k] > 35'(w_lo_b[other_axis(FACE_AXIS[f], k[0])])) &&
                    (r5_p[2*f+k] < 35'(w_hi_b[other_axis(FACE_AXIS[f], k[0])]));
            w_hit[f] = r5_ok[f] && w_in[2*f] && w_in[2*f+1];
        end
    end

    // SEL: first two hits in face order
    logic [2:0][31:0]   w_pt [NFACE];
    logic [2:0][31:0]   w_mg [NFACE];
    logic signed [34:0] w_nneg [NFACE];
    logic               w_h0, w_h1;
    logic [2:0]         w_f0, w_f1;
    logic [2:0][31:0]   w_pt0, w_pt1, w_mg0, w_mg1;

    always_comb begin
        for (int f = 0; f < NFACE; f++) begin
            w_nneg[f] = -r6_num[f];
            w_pt[f][FACE_AXIS[f]] = sat32(35'(r6_plane[f]));
            w_mg[f][FACE_AXIS[f]] = r6_num[f][34] ? w_nneg[f][31:0] : r6_num[f][31:0];
            for (int k = 0; k < 2; k++) begin
                w_pt[f][other_axis(FACE_AXIS[f], k[0])] = sat32(r6_p[2*f+k]);
                w_mg[f][other_axis(FACE_AXIS[f], k[0])] = r6_q[2*f+k][31:0];
            end
        end
        w_h0  = 1'b0;
        w_h1  = 1'b0;
        w_f0  = '0;
        w_f1  = '0;
        w_pt0 = '0;
        w_pt1 = '0;
        w_mg0 = '0;
        w_mg1 = '0;
        for (int f = 0; f < NFACE; f++) begin
            if (r6_hit[f]) begin
                if (!w_h0) begin
                    w_h0  = 1'b1;
                    w_f0  = 3'(f);
                    w_pt0 = w_pt[f];
                    w_mg0 = w_mg[f];
                end else if (!w_h1) begin
                    w_h1  = 1'b1;
                    w_f1  = 3'(f);
                    w_pt1 = w_pt[f];
                    w_mg1 = w_mg[f];
                end
            end
        end
    end

    logic               r7_v, r7_h0, r7_h1;
    logic [2:0]         r7_face [2];
    logic [2:0][31:0]   r7_pt [2];
    logic [2:0][31:0]   r7_mg [2];

    // squares, sum
    logic               r8_v, r8_h0, r8_h1;
    logic [2:0]         r8_face [2];
    logic [2:0][31:0]   r8_pt [2];
    logic [63:0]        r8_sq [2][3];

    logic               r9_v, r9_h0, r9_h1;
    logic [2:0]         r9_face [2];
    logic [2:0][31:0]   r9_pt [2];
    logic [65:0]        r9_sum [2];

    // square root stages
    logic               rs_v    [SQ_STG];
    logic               rs_h0   [SQ_STG];
    logic               rs_h1   [SQ_STG];
    logic [2:0]         rs_face [SQ_STG][2];
    logic [2:0][31:0]   rs_pt   [SQ_STG][2];
    logic [35:0]        rs_rem  [SQ_STG][2];
    logic [33:0]        rs_root [SQ_STG][2];
    logic [67:0]        rs_rad  [SQ_STG][2];

    // final rounding
    logic [34:0]        w_dist [2];
    logic               r10_v, r10_h0, r10_h1;
    logic [2:0]         r10_face [2];
    logic [2:0][31:0]   r10_pt [2];
    logic [32:0]        r10_dist [2];

    always_comb begin
        for (int j = 0; j < 2; j++)
            w_dist[j] = ({2'b00, rs_root[SQ_STG-1][j]} < rs_rem[SQ_STG-1][j])
                      ? 35'(rs_root[SQ_STG-1][j]) + 35'd1
                      : 35'(rs_root[SQ_STG-1][j]);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            for (int j = 0; j < DIV_STG; j++)
                rd_v[j] <= 1'b0;
            for (int j = 0; j < SQ_STG; j++)
                rs_v[j] <= 1'b0;
        end else if (i_adv) begin
            r1_v    <= i_in_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            rd_v[0] <= r3_v;
            for (int j = 1; j < DIV_STG; j++)
                rd_v[j] <= rd_v[j-1];
            r4_v    <= rd_v[DIV_STG-1];
            r5_v    <= r4_v;
            r6_v    <= r5_v;
            r7_v    <= r6_v;
            r8_v    <= r7_v;
            r9_v    <= r8_v;
            rs_v[0] <= r9_v;
            for (int j = 1; j < SQ_STG; j++)
                rs_v[j] <= rs_v[j-1];
            r10_v   <= rs_v[SQ_STG-1];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_s[i] <= $signed(i_s[i]);
                r1_e[i] <= $signed(i_e[i]);
                r2_s[i] <= r1_s[i];
                r2_dneg[i] <= w_d[i][32];
                r2_ud[i] <= w_d[i][32] ? w_dn[i][31:0] : w_d[i][31:0];
                r3_s[i] <= r2_s[i];
                r4_s[i] <= rd_s[DIV_STG-1][i];
            end
            r2_ok   <= w_ok;
            r3_dneg <= r2_dneg;
            r3_ok   <= r2_ok;
            for (int f = 0; f < NFACE; f++) begin
                r2_uden[f] <= w_den[f][34] ? w_dn[FACE_AXIS[f]][31:0] : w_den[f][31:0];
                r2_unum[f] <= w_num[f][34] ? w_nn[f][31:0] : w_num[f][31:0];
                r3_uden[f] <= r2_uden[f];
                for (int k = 0; k < 2; k++)
                    r3_prod[2*f+k] <= r2_unum[f] * r2_ud[other_axis(FACE_AXIS[f], k[0])];
            end

            rd_s[0]    <= r3_s;
            rd_dneg[0] <= r3_dneg;
            rd_ok[0]   <= r3_ok;
            rd_uden[0] <= r3_uden;
            for (int l = 0; l < NLANE; l++)
                {rd_rem[0][l], rd_lo[0][l]} <= div_steps(r3_prod[l][63:32],
                                                         r3_prod[l][31:0],
                                                         r3_uden[l/2]);
            for (int j = 1; j < DIV_STG; j++) begin
                rd_s[j]    <= rd_s[j-1];
                rd_dneg[j] <= rd_dneg[j-1];
                rd_ok[j]   <= rd_ok[j-1];
                rd_uden[j] <= rd_uden[j-1];
                for (int l = 0; l < NLANE; l++)
                    {rd_rem[j][l], rd_lo[j][l]} <= div_steps(rd_rem[j-1][l],
                                                             rd_lo[j-1][l],
                                                             rd_uden[j-1][l/2]);
            end

            r4_ok <= rd_ok[DIV_STG-1];
            r4_q  <= w_q;
            r4_neg <= w_neg;
            for (int f = 0; f < NFACE; f++) begin
                r4_plane[f] <= w_plane[f];
                r4_num[f]   <= w_num4[f];
            end

            r5_ok    <= r4_ok;
            r5_q     <= r4_q;
            r5_p     <= w_p;
            r5_plane <= r4_plane;
            r5_num   <= r4_num;

            r6_hit   <= w_hit;
            r6_q     <= r5_q;
            r6_p     <= r5_p;
            r6_plane <= r5_plane;
            r6_num   <= r5_num;

            r7_h0      <= w_h0;
            r7_h1      <= w_h1;
            r7_face[0] <= w_f0;
            r7_face[1] <= w_f1;
            r7_pt[0]   <= w_pt0;
            r7_pt[1]   <= w_pt1;
            r7_mg[0]   <= w_mg0;
            r7_mg[1]   <= w_mg1;

            r8_h0   <= r7_h0;
            r8_h1   <= r7_h1;
            r8_face <= r7_face;
            r8_pt   <= r7_pt;
            for (int j = 0; j < 2; j++)
                for (int i = 0; i < 3; i++)
                    r8_sq[j][i] <= r7_mg[j][i] * r7_mg[j][i];

            r9_h0   <= r8_h0;
            r9_h1   <= r8_h1;
            r9_face <= r8_face;
            r9_pt   <= r8_pt;
            for (int j = 0; j < 2; j++)
                r9_sum[j] <= 66'(r8_sq[j][0]) + 66'(r8_sq[j][1]) + 66'(r8_sq[j][2]);

            rs_h0[0]   <= r9_h0;
            rs_h1[0]   <= r9_h1;
            rs_face[0] <= r9_face;
            rs_pt[0]   <= r9_pt;
            for (int j = 0; j < 2; j++)
                {rs_rem[0][j], rs_root[0][j], rs_rad[0][j]} <=
                    sq_steps('0, '0, {2'b00, r9_sum[j]});
            for (int s = 1; s < SQ_STG; s++) begin
                rs_h0[s]   <= rs_h0[s-1];
                rs_h1[s]   <= rs_h1[s-1];
                rs_face[s] <= rs_face[s-1];
                rs_pt[s]   <= rs_pt[s-1];
                for (int j = 0; j < 2; j++)
                    {rs_rem[s][j], rs_root[s][j], rs_rad[s][j]} <=
                        sq_steps(rs_rem[s-1][j], rs_root[s-1][j], rs_rad[s-1][j]);
            end

            r10_h0   <= rs_h0[SQ_STG-1];
            r10_h1   <= rs_h1[SQ_STG-1];
            r10_face <= rs_face[SQ_STG-1];
            r10_pt   <= rs_pt[SQ_STG-1];
            for (int j = 0; j < 2; j++)
                r10_dist[j] <= (w_dist[j][34:33] != 2'b00) ? '1 : w_dist[j][32:0];
        end
    end

    always_comb begin
        o_out.valid    = r10_v;
        o_out.two      = r10_h1;
        o_out.r0.hit   = r10_h0;
        o_out.r0.face  = r10_face[0];
        o_out.r0.point = r10_pt[0];
        o_out.r0.dlen  = r10_dist[0];
        o_out.r1.hit   = r10_h1;
        o_out.r1.face  = r10_face[1];
        o_out.r1.point = r10_pt[1];
        o_out.r1.dlen  = r10_dist[1];
    end

endmodule

// File: rtl/core/segment_box_face_intersect_unit.sv
// Top level of the segment / box face intersect unit.
// Holds the box registers and the result word sequencing around sbfi_core.
// Depends on sbfi_pkg and sbfi_core.
//
// Takes one segment per clock while busy is low and returns one result word
// per face hit (at most two, first two in face order) or a single miss word,
// last set on the final word of each segment. Words pass the 16-stage quotient
// and the 17-stage square root pipelines. Result words cannot be held off:
// each is valid for exactly one cycle. A segment with two hits holds busy for
// one cycle while its first word is out and its second is loaded, which
// freezes the pipeline. Box registers are written through the cfg channel,
// always ready; the user must write them only while idle (the block has no check).
module segment_box_face_intersect_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_start_z,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_end_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic               o_hit,
    output logic [2:0]         o_face,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z,
    output logic [32:0]        o_distance,
    output logic               o_last
);
    import sbfi_pkg::*;

    t_box       r_box, n_box;
    t_core_out  w_core;
    t_res       r_res, n_res;
    t_res       r_b, n_b;
    logic       r_valid, n_valid;
    logic       r_last, n_last;
    logic       r_pend, n_pend;
    logic       w_adv;

    assign w_adv       = !r_pend;
    assign busy        = r_pend;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_box = r_box;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CENTER_X: n_box.center[0] = i_cfg_data;
                CFG_CENTER_Y: n_box.center[1] = i_cfg_data;
                CFG_CENTER_Z: n_box.center[2] = i_cfg_data;
                CFG_HALF_X:   n_box.half[0]   = i_cfg_data[30:0];
                CFG_HALF_Y:   n_box.half[1]   = i_cfg_data[30:0];
                CFG_HALF_Z:   n_box.half[2]   = i_cfg_data[30:0];
                default:      n_box = r_box;
            endcase
        end
    end

    sbfi_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_in_valid (start && !busy),
        .i_s        ({i_start_z, i_start_y, i_start_x}),
        .i_e        ({i_end_z, i_end_y, i_end_x}),
        .i_box      (r_box),
        .o_out      (w_core)
    );

    // second hit word waits in r_b while the pipeline holds
    always_comb begin
        n_valid = 1'b0;
        n_pend  = 1'b0;
        n_res   = r_res;
        n_last  = r_last;
        n_b     = r_b;
        if (r_pend) begin
            n_valid = 1'b1;
            n_res   = r_b;
            n_last  = 1'b1;
        end else if (w_core.valid) begin
            n_valid = 1'b1;
            n_res   = w_core.r0.hit ? w_core.r0 : '0;
            n_last  = !w_core.two;
            n_pend  = w_core.two;
            n_b     = w_core.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.center <= '0;
            r_box.half   <= {3{HALF_RESET}};
            r_valid      <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_box   <= n_box;
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_last <= n_last;
        r_b    <= n_b;
    end

    assign o_valid    = r_valid;
    assign o_hit      = r_res.hit;
    assign o_face     = r_res.face;
    assign o_point_x  = $signed(r_res.point[0]);
    assign o_point_y  = $signed(r_res.point[1]);
    assign o_point_z  = $signed(r_res.point[2]);
    assign o_distance = r_res.dlen;
    assign o_last     = r_last;

endmodule

// File: rtl/core/sbfi_checker.sv
// Port-level checks for segment_box_face_intersect_unit, bound to the top.
// No package dependency.
module sbfi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_valid,
    input logic        o_hit,
    input logic [2:0]  o_face,
    input logic [32:0] o_distance,
    input logic        o_last
);

    a_busy_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> o_valid && o_hit && !o_last)
        else $error("busy without a first hit word");

    a_busy_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid && o_hit && o_last && !busy)
        else $error("second hit word missing after busy");

    a_miss_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_last && o_face == 3'd0 && o_distance == 33'd0)
        else $error("malformed miss word");

    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("non-final word without hold");

    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_face <= 3'd5)
        else $error("face index out of range");

endmodule

bind segment_box_face_intersect_unit sbfi_checker u_sbfi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_hit      (o_hit),
    .o_face     (o_face),
    .o_distance (o_distance),
    .o_last     (o_last)
);
